/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. They compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMPLY(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(label, pre, post)
`define ASSERT_NEXT(label, pre, post)

`endif

`endif

/* design/wrms_pkg.sv */
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared widths, register indexes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package wrms_pkg;

	localparam int MID_W   = 10;   // mid_offset register
	localparam int GAIN_W  = 16;   // Q4.12 gains
	localparam int DATA_W  = 16;   // config write data, widest register
	localparam int IDX_W   = 2;    // config register index
	localparam int SUM_W   = 43;   // square accumulator
	localparam int RMS_W   = 18;   // result
	localparam int ROOT_W  = 22;   // root of a SUM_W-bit value (SUM_W padded to even)
	localparam int STEP_W  = 6;    // holds ROOT_W - 1
	localparam int SB_MAX  = 12;   // widest supported sample

	localparam logic [MID_W-1:0]  MID_RST   = MID_W'(512);
	localparam logic [GAIN_W-1:0] VGAIN_RST = GAIN_W'(4396);
	localparam logic [GAIN_W-1:0] IGAIN_RST = GAIN_W'(2299);

	typedef enum logic [IDX_W-1:0] {
		REG_MID_OFFSET     = 2'd0,
		REG_VOLTAGE_GAIN   = 2'd1,
		REG_CURRENT_GAIN   = 2'd2,
		REG_CHANNEL_SELECT = 2'd3
	} cfg_reg_t;

	// one closed window waiting for the root unit
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             chan;
	} wrms_entry_t;

endpackage

/* design/windowed_rms_meter.sv */
// ----------------------------------------------------------------------------
// windowed_rms_meter
// True RMS of WINDOW converter samples, offset removed and gain scaled.
//   Input beat: sample, on sample_valid/sample_ready. One result beat
//   (rms_value, from_channel) per WINDOW samples on result_valid/result_ready.
//   Config: cfg_we/cfg_index/cfg_data, one register per cycle, no wait.
//   Front: a sample is accepted per cycle while sample_ready is high;
//   scale, square and accumulate follow as registered stages. A window's
//   last sample holds the input off until its sum reaches the two-entry
//   queue, and a full queue also holds it off.
//   Back: serial root of the window sum against WINDOW * root^2 (no divide),
//   then the result register, which drives result_valid. The root unit takes
//   a new window only after the last one is loaded into the result register.
//   A stalled result waits in its register while the back works on the next.
//   Reset: registers to defaults, accumulator and window count cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_rms_meter import wrms_pkg::*; #(
	parameter int WINDOW      = 40,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [RMS_W-1:0]       rms_value,
	output logic                   from_channel
);

	logic        q_push, q_pop, q_full, q_empty;
	wrms_entry_t push_entry, pop_entry;

	// front: config, scale/square pipeline, accumulator
	wrms_front #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.q_full       (q_full),
		.push         (q_push),
		.push_entry   (push_entry)
	);

	// closed windows wait here
	wrms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	// back: mean and root, result register
	wrms_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_entry      (pop_entry),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.rms_value    (rms_value),
		.from_channel (from_channel)
	);

	// queue never overruns or underruns
	`ASSERT_IMPLY(a_no_push_full, q_push, !q_full)
	`ASSERT_IMPLY(a_no_pop_empty, q_pop, !q_empty)
	// input held off while the queue has no room
	`ASSERT_IMPLY(a_full_blocks_input, q_full, !sample_ready)
	// a pushed window is visible to the back next cycle
	`ASSERT_NEXT(a_push_lands, q_push, !q_empty)

endmodule

/* design/wrms_front.sv */
// ----------------------------------------------------------------------------
// wrms_front
// Config registers, offset/gain/square pipeline, window accumulator.
// ----------------------------------------------------------------------------
module wrms_front import wrms_pkg::*; #(
	parameter int WINDOW      = 40,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   q_full,
	output logic                   push,
	output wrms_entry_t            push_entry
);

	localparam int CNT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PROD_W = SAMPLE_BITS + GAIN_W;
	localparam int MAG_W  = PROD_W - 8;
	localparam int SQ_W   = 2 * MAG_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

	logic [MID_W-1:0]  mid_q;
	logic [GAIN_W-1:0] vgain_q, igain_q;
	logic              chsel_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;

	logic                   v_s1, last_s1, chan_s1;
	logic [SAMPLE_BITS-1:0] absd_s1;
	logic [GAIN_W-1:0]      gain_s1;
	logic                   v_s2, last_s2, chan_s2;
	logic [MAG_W-1:0]       mag_s2;
	logic                   v_s3, last_s3, chan_s3;
	logic [SQ_W-1:0]        sq_s3;

	logic [SB_MAX-1:0]      mid_wide;
	logic [SAMPLE_BITS-1:0] mid_s, absd;
	logic                   accept, last_in;
	logic [PROD_W-1:0]      prod, prod_rnd;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       sum_sat;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q   <= MID_RST;
			vgain_q <= VGAIN_RST;
			igain_q <= IGAIN_RST;
			chsel_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MID_OFFSET:     mid_q   <= cfg_data[MID_W-1:0];
				REG_VOLTAGE_GAIN:   vgain_q <= cfg_data[GAIN_W-1:0];
				REG_CURRENT_GAIN:   igain_q <= cfg_data[GAIN_W-1:0];
				REG_CHANNEL_SELECT: chsel_q <= cfg_data[0];
			endcase
		end
	end

	// offset taken in sample width
	assign mid_wide = {{(SB_MAX - MID_W){1'b0}}, mid_q};
	assign mid_s    = mid_wide[SAMPLE_BITS-1:0];
	assign absd     = (sample >= mid_s) ? (sample - mid_s) : (mid_s - sample);

	// only one window close in flight, so the queue can always take it
	assign sample_ready = !q_full && !(v_s1 && last_s1) && !(v_s2 && last_s2)
		&& !(v_s3 && last_s3);
	assign accept  = sample_valid && sample_ready;
	assign last_in = (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= last_in ? '0 : cnt_q + CNT_W'(1);
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign prod     = PROD_W'(absd_s1) * PROD_W'(gain_s1);
	assign prod_rnd = prod + PROD_W'(128);

	always_ff @(posedge clk) begin
		absd_s1 <= absd;
		gain_s1 <= chsel_q ? igain_q : vgain_q;
		last_s1 <= last_in;
		chan_s1 <= chsel_q;
		mag_s2  <= prod_rnd[PROD_W-1:8];
		last_s2 <= last_s1;
		chan_s2 <= chan_s1;
		sq_s3   <= SQ_W'(mag_s2) * SQ_W'(mag_s2);
		last_s3 <= last_s2;
		chan_s3 <= chan_s2;
	end

	// saturating accumulate
	assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sq_s3);
	assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v_s3) begin
			sum_q <= last_s3 ? '0 : sum_sat;
		end
	end

	assign push            = v_s3 && last_s3;
	assign push_entry.sum  = sum_sat;
	assign push_entry.chan = chan_s3;

endmodule

/* design/wrms_queue.sv */
// ----------------------------------------------------------------------------
// wrms_queue
// Two-entry FIFO of closed windows between front and back.
// ----------------------------------------------------------------------------
module wrms_queue import wrms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  wrms_entry_t push_entry,
	input  logic        pop,
	output wrms_entry_t pop_entry,
	output logic        full,
	output logic        empty
);

	wrms_entry_t mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign pop_entry = mem_q[rd_ptr_q];
	assign full      = (count_q == 2'd2);
	assign empty     = (count_q == 2'd0);

endmodule

/* design/wrms_back.sv */
// ----------------------------------------------------------------------------
// wrms_back
// Bit-pair square root of the window mean, result register.
// ----------------------------------------------------------------------------
module wrms_back import wrms_pkg::*; #(
	parameter int WINDOW = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  wrms_entry_t      q_entry,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [RMS_W-1:0] rms_value,
	output logic             from_channel
);

	// floor(sqrt(floor(S / WINDOW))) is the largest r with WINDOW * r * r <= S,
	// so the root runs on S directly with every trial scaled by WINDOW
	localparam int RW   = $clog2(WINDOW + 1) + 1;
	localparam int WR_W = ROOT_W + RW;
	localparam int SR_W = WR_W + 2;
	localparam int WK_W = 2 * ROOT_W;
	localparam logic [SR_W-1:0]   WIN_TRIAL  = SR_W'(WINDOW);
	localparam logic [WR_W-1:0]   WIN_STEP   = WR_W'(WINDOW);
	localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(ROOT_W - 1);
	localparam logic [ROOT_W-1:0] RMS_MAX    = ROOT_W'({RMS_W{1'b1}});

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROOT = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [WK_W-1:0]   work_q;
	logic [SR_W-1:0]   srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [WR_W-1:0]   wroot_q;   // WINDOW * root_q
	logic [STEP_W-1:0] step_q;
	logic              chan_q;
	logic              res_valid_q;
	logic [RMS_W-1:0]  rms_q;
	logic              res_chan_q;

	logic [SR_W-1:0] srem_sh, trial;
	logic            root_ge;
	logic            load;

	// root step: bring down next bit pair, trial is WINDOW * (4 * root + 1)
	assign srem_sh = {srem_q[SR_W-3:0], work_q[WK_W-1 -: 2]};
	assign trial   = {wroot_q, 2'b00} + WIN_TRIAL;
	assign root_ge = (srem_sh >= trial);

	assign pop  = (state_q == ST_IDLE) && !q_empty;
	assign load = (state_q == ST_DONE) && (!res_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_ROOT;
						step_q  <= ROOT_STEPS;
					end
				end
				ST_ROOT: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				work_q  <= {{(WK_W - SUM_W){1'b0}}, q_entry.sum};
				srem_q  <= '0;
				root_q  <= '0;
				wroot_q <= '0;
				chan_q  <= q_entry.chan;
			end
			ST_ROOT: begin
				srem_q  <= root_ge ? (srem_sh - trial) : srem_sh;
				root_q  <= {root_q[ROOT_W-2:0], root_ge};
				wroot_q <= {wroot_q[WR_W-2:0], 1'b0} + (root_ge ? WIN_STEP : {WR_W{1'b0}});
				work_q  <= {work_q[WK_W-3:0], 2'b00};
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// result register; back may start the next window while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rms_q      <= (root_q > RMS_MAX) ? {RMS_W{1'b1}} : root_q[RMS_W-1:0];
			res_chan_q <= chan_q;
		end
	end

	assign result_valid = res_valid_q;
	assign rms_value    = rms_q;
	assign from_channel = res_chan_q;

endmodule

/* tb/wrms_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wrms_checker
// Watches the config port and both beat channels of windowed_rms_meter. It
// keeps its own register copy and window accumulator, works out the reading
// due at the close of each window, and compares every result beat with the
// oldest reading still due.
// ----------------------------------------------------------------------------
module wrms_checker import wrms_pkg::*; #(
	parameter int WINDOW      = 40,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	input  logic                   sample_valid,
	input  logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  logic [RMS_W-1:0]       rms_value,
	input  logic                   from_channel,
	output int                     mismatches,
	output int                     pending
);

	typedef struct packed {
		logic [RMS_W-1:0] rms;
		logic             chan;
	} reading_t;

	localparam logic [SUM_W-1:0] SUM_CEIL = '1;
	localparam logic [RMS_W-1:0] RMS_CEIL = '1;

	logic [MID_W-1:0]  mid_q;
	logic [GAIN_W-1:0] vgain_q;
	logic [GAIN_W-1:0] igain_q;
	logic              chan_q;
	logic [SUM_W-1:0]  energy;
	int                fill;
	int                fail_cnt;
	reading_t          readings_due[$];

	// |sample - offset| times channel gain, Q4.12 down to 1/16 steps, rounded
	function automatic logic [31:0] scaled_mag(input logic [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS-1:0] m;
		logic [SAMPLE_BITS-1:0] d;
		logic [GAIN_W-1:0]      g;
		logic [47:0]            prod;
		m = SAMPLE_BITS'(mid_q);
		d = (s >= m) ? s - m : m - s;
		g = chan_q ? igain_q : vgain_q;
		prod = 48'(d) * 48'(g) + 48'd128;
		return 32'(prod >> 8);
	endfunction

	// floor square root, one result bit per pass from the top down
	function automatic logic [RMS_W-1:0] floor_root(input logic [SUM_W-1:0] v);
		logic [63:0] acc;
		logic [63:0] trial;
		acc = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = acc | (64'd1 << b);
			if (trial * trial <= 64'(v))
				acc = trial;
		end
		if (acc > 64'(RMS_CEIL))
			return RMS_CEIL;
		return acc[RMS_W-1:0];
	endfunction

	task automatic flag(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t wrms_checker: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t    got;
		reading_t    want;
		logic [31:0] mag;
		logic [63:0] total;
		if (!arst_n) begin
			mid_q    = MID_RST;
			vgain_q  = VGAIN_RST;
			igain_q  = IGAIN_RST;
			chan_q   = 1'b0;
			energy   = '0;
			fill     = 0;
			fail_cnt = 0;
			readings_due.delete();
			pending    <= 0;
			mismatches <= 0;
		end else begin
			if (result_valid && result_ready) begin
				got.rms  = rms_value;
				got.chan = from_channel;
				if (readings_due.size() == 0) begin
					flag($sformatf("result beat with none due: rms %0d chan %0d",
						got.rms, got.chan));
				end else begin
					want = readings_due.pop_front();
					if (got.rms !== want.rms || got.chan !== want.chan)
						flag($sformatf("rms exp %0d got %0d, chan exp %0d got %0d",
							want.rms, got.rms, want.chan, got.chan));
				end
			end

			if (sample_valid && sample_ready) begin
				mag   = scaled_mag(sample);
				total = 64'(energy) + 64'(mag) * 64'(mag);
				energy = (total > 64'(SUM_CEIL)) ? SUM_CEIL : total[SUM_W-1:0];
				fill++;
				if (fill >= WINDOW) begin
					want.rms  = floor_root(energy / SUM_W'(WINDOW));
					want.chan = chan_q;
					readings_due.push_back(want);
					energy = '0;
					fill   = 0;
				end
			end

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MID_OFFSET:     mid_q   = cfg_data[MID_W-1:0];
					REG_VOLTAGE_GAIN:   vgain_q = cfg_data[GAIN_W-1:0];
					REG_CURRENT_GAIN:   igain_q = cfg_data[GAIN_W-1:0];
					REG_CHANNEL_SELECT: chan_q  = cfg_data[0];
					default: ;
				endcase
			end

			pending    <= readings_due.size();
			mismatches <= fail_cnt;
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for windowed_rms_meter. Drives sample beats with
// random gaps, a randomly stalling result side, and register writes between
// phases once the back end has drained. All checking sits in wrms_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import wrms_pkg::*;

	localparam int WINDOW       = 40;
	localparam int SAMPLE_BITS  = 10;
	localparam int ITEM_GOAL    = 900;
	localparam int RANDOM_GOAL  = 6 * WINDOW;   // random beats: a handful of windows
	localparam int DRAIN_CYCLES = 120;          // margin for the last window to reach the result port
	localparam int HOLD_CYCLES  = 800;          // long result-side stall
	localparam int SETTLE_LIMIT = 50000;

	typedef enum {MIX_FULL, MIX_EDGE, MIX_NEAR} sample_mix_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [IDX_W-1:0]       cfg_index;
	logic [DATA_W-1:0]      cfg_data;
	logic                   sample_valid;
	logic                   sample_ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   result_valid;
	logic                   result_ready;
	logic [RMS_W-1:0]       rms_value;
	logic                   from_channel;

	int mismatches;
	int pending;
	int beats_sent;
	int hold_requests;  // bumped by stimulus, served by the receiver
	int holds_served;
	logic [MID_W-1:0] mid_now;  // offset as last written, to aim samples near zero

	windowed_rms_meter #(
		.WINDOW(WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.rms_value(rms_value),
		.from_channel(from_channel)
	);

	wrms_checker #(
		.WINDOW(WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) meter_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.rms_value(rms_value),
		.from_channel(from_channel),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#8000000;
		$display("Regression FAIL");
		$finish;
	end

	// idle stretch: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(30, 90);
	endfunction

	// register data: rails now and then, otherwise any 16 bits (upper bits
	// of the narrow registers must be dropped by the block)
	function automatic logic [DATA_W-1:0] reg_data();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sample_mix_t mix);
		case (mix)
			MIX_EDGE: begin
				// converter rails and a few counts in from them
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return SAMPLE_BITS'($urandom_range(0, 3));
					default: return ~SAMPLE_BITS'($urandom_range(0, 3));
				endcase
			end
			MIX_NEAR: return SAMPLE_BITS'(mid_now) + SAMPLE_BITS'($urandom_range(0, 8))
				- SAMPLE_BITS'(4);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// result side: ready runs broken by random gaps; a pending hold request
	// drops ready for HOLD_CYCLES so results back up into the block
	initial begin : receiver
		int span;
		result_ready = 1'b0;
		holds_served = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				result_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
				span = idle_gap();
				if (span > 0) begin
					result_ready <= 1'b0;
					repeat (span) @(posedge clk);
				end
			end
		end
	end

	// one sample beat; valid stays up into the next beat when there is no gap
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input bit no_gap);
		int span;
		sample_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (!sample_ready);
		beats_sent++;
		span = no_gap ? 0 : idle_gap();
		if (span > 0) begin
			sample_valid <= 1'b0;
			repeat (span) @(posedge clk);
		end
	endtask

	task automatic send_run(input int count, input sample_mix_t mix, input bit no_gap);
		for (int i = 0; i < count; i++)
			send_sample(pick_sample(mix), no_gap);
	endtask

	// quiet the input, wait until no reading is due, then let the front
	// pipeline and any window still in the back end run out
	task automatic settle();
		int waited;
		waited = 0;
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// the trailing wait keeps cfg_we from being dropped and raised in one step
	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == REG_MID_OFFSET)
			mid_now = value[MID_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int          random_beats;
		int          run;
		bit          steady;
		sample_mix_t mix;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_MID_OFFSET;
		cfg_data      = '0;
		sample_valid  = 1'b0;
		sample        = '0;
		beats_sent    = 0;
		hold_requests = 0;
		mid_now       = MID_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: rails, mid-scale, one count either side of it,
		// alternating bit patterns; random fill closes the window
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(10'h200, 1'b0);
		send_sample(10'h1FF, 1'b0);
		send_sample(10'h201, 1'b0);
		send_sample(10'h001, 1'b0);
		send_sample(10'h3FE, 1'b0);
		send_sample(10'h155, 1'b0);
		send_sample(10'h2AA, 1'b0);
		send_sample(10'h200, 1'b0);
		send_run(WINDOW - 10, MIX_FULL, 1'b0);

		// channel flips to current part way through a window; earlier
		// samples keep the voltage gain and the window is not restarted
		send_run(15, MIX_FULL, 1'b0);
		settle();
		write_reg(REG_CHANNEL_SELECT, 16'h0001);
		send_run(WINDOW - 15, MIX_FULL, 1'b0);

		// full gain with offset at the bottom rail (high bits must be dropped)
		settle();
		write_reg(REG_MID_OFFSET, 16'hFC00);
		write_reg(REG_CURRENT_GAIN, 16'hFFFF);
		send_run(WINDOW, MIX_EDGE, 1'b0);

		// offset at the top rail
		settle();
		write_reg(REG_MID_OFFSET, 16'h03FF);
		send_run(WINDOW, MIX_EDGE, 1'b0);

		// zero gain reads zero whatever the samples
		settle();
		write_reg(REG_CURRENT_GAIN, 16'h0000);
		send_run(WINDOW, MIX_FULL, 1'b0);

		// back to voltage (bit 0 clear, upper bits set), smallest nonzero gain
		settle();
		write_reg(REG_CHANNEL_SELECT, 16'hFFFE);
		write_reg(REG_VOLTAGE_GAIN, 16'h0001);
		send_run(WINDOW, MIX_FULL, 1'b0);

		// largest voltage gain around mid-scale
		settle();
		write_reg(REG_MID_OFFSET, 16'h0200);
		write_reg(REG_VOLTAGE_GAIN, 16'hFFFF);
		send_run(WINDOW, MIX_NEAR, 1'b0);

		// back pressure: receiver stops for a long stretch while samples
		// keep coming with no gaps, until the block holds its input off
		settle();
		write_reg(REG_VOLTAGE_GAIN, VGAIN_RST);
		hold_requests = hold_requests + 1;
		wait (holds_served == hold_requests);
		@(posedge clk);
		send_run(8 * WINDOW, MIX_FULL, 1'b1);

		// random phases: a few registers rewritten between phases, runs that
		// end mid-window so settings change inside windows too
		random_beats = 0;
		while (beats_sent < ITEM_GOAL || random_beats < RANDOM_GOAL) begin
			settle();
			if ($urandom_range(0, 1))
				write_reg(REG_MID_OFFSET, reg_data());
			if ($urandom_range(0, 1))
				write_reg(REG_VOLTAGE_GAIN, reg_data());
			if ($urandom_range(0, 1))
				write_reg(REG_CURRENT_GAIN, reg_data());
			if ($urandom_range(0, 1))
				write_reg(REG_CHANNEL_SELECT, DATA_W'($urandom));
			mix    = sample_mix_t'($urandom_range(0, 2));
			steady = ($urandom_range(0, 3) == 0);
			run    = $urandom_range(1, 3 * WINDOW);
			send_run(run, mix, steady);
			random_beats += run;
		end

		settle();
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
